// ===== design/first_fit_free_list_allocator_assert.svh =====
// Assertion macros for the allocator RTL.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FFA_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("allocator assertion failed");

// Next-cycle implication.
`define FFA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("allocator assertion failed");

`endif

// ===== design/ffa_pkg.sv =====
// Shared types and constants for the first-fit free-list allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

    // Default sizing.
    localparam int POOL_WORDS_DEF = 4096;
    localparam int WORD_BYTES_DEF = 8;

    // Field and datapath widths.
    localparam int BYTES_W  = 16;
    localparam int FADDR_W  = 12;
    localparam int STATUS_W = 2;
    localparam int CELL_W   = 17;
    localparam int SUM_W    = 19;
    localparam int HDR_WORDS = 2;

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_FIX,
        S_FCHK,
        S_NODE,
        S_LINK,
        S_SPACE,
        S_WRITE,
        S_DONE
    } state_t;

    // Pool memory port controls.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

`default_nettype wire

// ===== design/ffa_pool.sv =====
// Pool word memory: one write port and one registered read port.
// Depends on ffa_pkg for the memory control struct and cell width.
`timescale 1ns / 1ps
`default_nettype none

module ffa_pool #(
    parameter int POOL_WORDS = ffa_pkg::POOL_WORDS_DEF
) (
    input  wire logic                          clk,
    input  wire ffa_pkg::mem_ctl_t             ctl,
    input  wire logic [$clog2(POOL_WORDS)-1:0] raddr,
    input  wire logic [$clog2(POOL_WORDS)-1:0] waddr,
    input  wire logic [ffa_pkg::CELL_W-1:0]    wdata,
    output logic      [ffa_pkg::CELL_W-1:0]    rdata
);

    logic [ffa_pkg::CELL_W-1:0] mem [POOL_WORDS];

    // Synchronous write.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Synchronous read into a registered output.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/first_fit_free_list_allocator.sv =====
// First-fit free-list allocator top level: request sequencer and result register.
// Depends on ffa_pkg, ffa_pool and first_fit_free_list_allocator_assert.svh.
//
// Usage: one request channel (in_valid/in_ready with kind, request_bytes,
// free_address) and one result channel (out_valid/out_ready with
// granted_address, status). Every request gives exactly one result.
// After reset the block sweeps the pool memory, one word a cycle, and keeps
// in_ready low until the sweep is done.
// Requests are handled one at a time. Each free range visited on the list
// is handled as a link read, a size read and a decision, through the single
// memory read port. A zero-size allocate, a null free or a free address
// whose header lies outside the pool goes straight to its result without
// walking the list, and a free whose range runs past the pool finishes once
// its size word is read, also without walking the list.
// The finished result sits in an output register; a new request is taken
// while it waits, and the sequencer only holds at its last step when the
// receiver has not yet taken the previous transfer.
`timescale 1ns / 1ps
`default_nettype none

`include "first_fit_free_list_allocator_assert.svh"

module first_fit_free_list_allocator #(
    parameter int POOL_WORDS = ffa_pkg::POOL_WORDS_DEF,
    parameter int WORD_BYTES = ffa_pkg::WORD_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            kind,
    input  wire logic [ffa_pkg::BYTES_W-1:0]     request_bytes,
    input  wire logic [ffa_pkg::FADDR_W-1:0]     free_address,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [ffa_pkg::FADDR_W-1:0]     granted_address,
    output logic      [ffa_pkg::STATUS_W-1:0]    status
);

    localparam int AW    = $clog2(POOL_WORDS);
    localparam int CNT_W = AW + 1;
    localparam int SW    = ffa_pkg::SUM_W;
    localparam int CW    = ffa_pkg::CELL_W;
    localparam int XW    = ffa_pkg::BYTES_W + 1;
    localparam int DIV_SHIFT = XW;
    localparam int RW    = XW + 1;
    localparam int PW    = XW + RW;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << DIV_SHIFT) / WORD_BYTES);
    localparam logic [SW-1:0] POOL_S  = SW'(POOL_WORDS);
    localparam logic [CW-1:0] NIL_C   = CW'(POOL_WORDS);
    localparam logic [CW-1:0] INIT_SZ = CW'(POOL_WORDS - ffa_pkg::HDR_WORDS);
    localparam logic [SW-1:0] HDR_S   = SW'(ffa_pkg::HDR_WORDS);
    localparam logic [CNT_W-1:0] POOL_N = CNT_W'(POOL_WORDS);

    ffa_pkg::state_t state_reg, state_next;

    logic              kind_reg, kind_next;
    logic [XW-1:0]     x_reg, x_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [XW-1:0]     words_reg, words_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic [AW-1:0]     prev_reg, prev_next;
    logic              has_prev_reg, has_prev_next;
    logic [CW-1:0]     link_reg, link_next;
    logic [CW-1:0]     psize_reg, psize_next;
    logic [SW-1:0]     part_reg, part_next;
    logic [SW-1:0]     adj_reg, adj_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [AW-1:0]     head_reg, head_next;
    logic              head_valid_reg, head_valid_next;
    logic              rd_oob_reg, rd_oob_next;
    logic [SW-1:0]     wa_reg [4];
    logic [SW-1:0]     wa_next [4];
    logic [CW-1:0]     wd_reg [4];
    logic [CW-1:0]     wd_next [4];
    logic [3:0]        we_reg, we_next;
    logic [1:0]        widx_reg, widx_next;
    logic [CNT_W-1:0]  clr_reg, clr_next;
    logic [ffa_pkg::FADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [ffa_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [ffa_pkg::FADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [ffa_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    ffa_pkg::mem_ctl_t mem_ctl;
    logic [AW-1:0]     mem_raddr;
    logic [AW-1:0]     mem_waddr;
    logic [CW-1:0]     mem_wdata;
    logic [CW-1:0]     mem_rdata;

    // Decoded helper terms.
    logic              accept;
    logic              out_free;
    logic [SW-1:0]     fa_s;
    logic [SW-1:0]     fpart_s;
    logic              free_bad;
    logic [SW-1:0]     space_s;
    logic [SW-1:0]     words_s;
    logic [SW-1:0]     link_s;
    logic [SW-1:0]     cur_p1;
    logic [XW-1:0]     q0;
    logic [XW-1:0]     rem0;
    logic [SW-1:0]     diff_s;
    logic [SW-1:0]     split_s;
    logic              walk_end;
    logic [SW-1:0]     head_link_s;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign fa_s     = SW'(free_address);
    assign fpart_s  = fa_s - HDR_S;
    assign free_bad = (fa_s < HDR_S) || (fpart_s + SW'(1) >= POOL_S);
    assign space_s  = rd_oob_reg ? '0 : SW'(mem_rdata);
    assign words_s  = SW'(words_reg);
    assign link_s   = SW'(link_reg);
    assign cur_p1   = cur_reg + SW'(1);
    assign q0       = XW'(prod_reg >> DIV_SHIFT);
    assign rem0     = x_reg - XW'(q0 * XW'(WORD_BYTES));
    assign diff_s   = space_s - words_s;
    assign split_s  = cur_reg + HDR_S + words_s;
    assign walk_end = (cur_reg >= POOL_S) || (n_reg == POOL_N);
    assign head_link_s = head_valid_reg ? SW'(head_reg) : POOL_S;

    ffa_pool #(
        .POOL_WORDS(POOL_WORDS)
    ) u_pool (
        .clk   (clk),
        .ctl   (mem_ctl),
        .raddr (mem_raddr),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffa_pkg::S_CLEAR:
            begin
                if (clr_reg == POOL_N - CNT_W'(1))
                begin
                    state_next = ffa_pkg::S_IDLE;
                end
            end
            ffa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == ffa_pkg::KIND_ALLOC)
                    begin
                        state_next = (request_bytes == '0) ? ffa_pkg::S_DONE
                                                           : ffa_pkg::S_DIV;
                    end
                    else if (free_address == '0 || free_bad)
                    begin
                        state_next = ffa_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = ffa_pkg::S_FCHK;
                    end
                end
            end
            ffa_pkg::S_DIV:   state_next = ffa_pkg::S_FIX;
            ffa_pkg::S_FIX:   state_next = ffa_pkg::S_NODE;
            ffa_pkg::S_FCHK:
            begin
                if (part_reg + SW'(mem_rdata) + HDR_S > POOL_S)
                begin
                    state_next = ffa_pkg::S_DONE;
                end
                else
                begin
                    state_next = ffa_pkg::S_NODE;
                end
            end
            ffa_pkg::S_NODE:
            begin
                if (walk_end)
                begin
                    state_next = (kind_reg == ffa_pkg::KIND_ALLOC) ? ffa_pkg::S_DONE
                                                                   : ffa_pkg::S_WRITE;
                end
                else
                begin
                    state_next = ffa_pkg::S_LINK;
                end
            end
            ffa_pkg::S_LINK:  state_next = ffa_pkg::S_SPACE;
            ffa_pkg::S_SPACE:
            begin
                if (kind_reg == ffa_pkg::KIND_ALLOC)
                begin
                    state_next = (space_s >= words_s) ? ffa_pkg::S_WRITE : ffa_pkg::S_NODE;
                end
                else if (cur_reg == adj_reg || cur_reg + space_s + HDR_S == part_reg)
                begin
                    state_next = ffa_pkg::S_WRITE;
                end
                else
                begin
                    state_next = ffa_pkg::S_NODE;
                end
            end
            ffa_pkg::S_WRITE:
            begin
                if (widx_reg == 2'd3)
                begin
                    state_next = ffa_pkg::S_DONE;
                end
            end
            ffa_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = ffa_pkg::S_IDLE;
                end
            end
            default:  state_next = ffa_pkg::S_IDLE;
        endcase
    end

    // Memory port and handshake outputs of the sequencer.
    always_comb
    begin
        mem_ctl     = '0;
        mem_raddr   = '0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        rd_oob_next = 1'b0;
        in_ready    = 1'b0;
        case (state_reg)
            ffa_pkg::S_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = clr_reg[AW-1:0];
                if (clr_reg == '0)
                begin
                    mem_wdata = NIL_C;
                end
                else if (clr_reg == CNT_W'(1))
                begin
                    mem_wdata = INIT_SZ;
                end
            end
            ffa_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                // Fetch the size word of the range being freed.
                mem_ctl.rd_en = accept && (kind == ffa_pkg::KIND_FREE);
                mem_raddr     = AW'(fpart_s + SW'(1));
            end
            ffa_pkg::S_NODE:
            begin
                mem_ctl.rd_en = !walk_end;
                mem_raddr     = cur_reg[AW-1:0];
            end
            ffa_pkg::S_LINK:
            begin
                rd_oob_next   = (cur_p1 >= POOL_S);
                mem_ctl.rd_en = !rd_oob_next;
                mem_raddr     = AW'(cur_p1);
            end
            ffa_pkg::S_WRITE:
            begin
                mem_ctl.wr_en = we_reg[widx_reg] && (wa_reg[widx_reg] < POOL_S);
                mem_waddr     = AW'(wa_reg[widx_reg]);
                mem_wdata     = wd_reg[widx_reg];
            end
            default:
            begin
                mem_ctl = '0;
            end
        endcase
    end

    // Datapath updates.
    always_comb
    begin
        kind_next       = kind_reg;
        x_next          = x_reg;
        prod_next       = prod_reg;
        words_next      = words_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        has_prev_next   = has_prev_reg;
        link_next       = link_reg;
        psize_next      = psize_reg;
        part_next       = part_reg;
        adj_next        = adj_reg;
        n_next          = n_reg;
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        wa_next         = wa_reg;
        wd_next         = wd_reg;
        we_next         = we_reg;
        widx_next       = widx_reg;
        clr_next        = clr_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;

        // The output register drops once the receiver takes the transfer.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ffa_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + CNT_W'(1);
            end
            ffa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    kind_next       = kind;
                    x_next          = XW'(request_bytes) + XW'(WORD_BYTES - 1);
                    part_next       = fpart_s;
                    cur_next        = head_link_s;
                    has_prev_next   = 1'b0;
                    n_next          = '0;
                    we_next         = '0;
                    widx_next       = '0;
                    res_addr_next   = '0;
                    res_status_next = ffa_pkg::ST_OK;
                    if (kind == ffa_pkg::KIND_ALLOC)
                    begin
                        if (request_bytes == '0)
                        begin
                            res_status_next = ffa_pkg::ST_ZERO;
                        end
                    end
                    else if (free_address != '0 && free_bad)
                    begin
                        res_status_next = ffa_pkg::ST_BAD_FREE;
                    end
                end
            end
            ffa_pkg::S_DIV:
            begin
                prod_next = PW'(x_reg) * PW'(RECIP);
            end
            ffa_pkg::S_FIX:
            begin
                // The reciprocal estimate is at most one below the quotient.
                words_next = (rem0 >= XW'(WORD_BYTES)) ? q0 + XW'(1) : q0;
            end
            ffa_pkg::S_FCHK:
            begin
                psize_next = mem_rdata;
                adj_next   = part_reg + SW'(mem_rdata) + HDR_S;
                if (part_reg + SW'(mem_rdata) + HDR_S > POOL_S)
                begin
                    res_status_next = ffa_pkg::ST_BAD_FREE;
                end
            end
            ffa_pkg::S_NODE:
            begin
                if (walk_end)
                begin
                    if (kind_reg == ffa_pkg::KIND_ALLOC)
                    begin
                        res_status_next = ffa_pkg::ST_NO_FIT;
                    end
                    else
                    begin
                        // No free neighbor: push the range onto the list head.
                        wa_next[0]      = part_reg;
                        wd_next[0]      = CW'(head_link_s);
                        we_next         = 4'b0001;
                        head_next       = part_reg[AW-1:0];
                        head_valid_next = 1'b1;
                    end
                end
            end
            ffa_pkg::S_LINK:
            begin
                link_next = mem_rdata;
            end
            ffa_pkg::S_SPACE:
            begin
                if (kind_reg == ffa_pkg::KIND_ALLOC && space_s >= words_s)
                begin
                    res_addr_next = ffa_pkg::FADDR_W'(cur_reg + HDR_S);
                    we_next       = '0;
                    if (diff_s > SW'(1))
                    begin
                        // Split: the remainder takes the range's list position.
                        wa_next[0] = split_s;
                        wd_next[0] = link_reg;
                        wa_next[1] = split_s + SW'(1);
                        wd_next[1] = CW'(diff_s - HDR_S);
                        wa_next[2] = cur_p1;
                        wd_next[2] = CW'(words_s);
                        we_next[2:0] = 3'b111;
                        wd_next[3] = CW'(split_s);
                    end
                    else
                    begin
                        wd_next[3] = link_reg;
                    end
                    wa_next[3] = SW'(prev_reg);
                    we_next[3] = has_prev_reg;
                    if (!has_prev_reg)
                    begin
                        if (SW'(wd_next[3]) >= POOL_S || (diff_s > SW'(1) && split_s >= POOL_S))
                        begin
                            head_valid_next = 1'b0;
                            head_next       = '0;
                        end
                        else
                        begin
                            head_valid_next = 1'b1;
                            head_next       = (diff_s > SW'(1)) ? split_s[AW-1:0]
                                                                : link_reg[AW-1:0];
                        end
                    end
                end
                else if (kind_reg == ffa_pkg::KIND_FREE && cur_reg == adj_reg)
                begin
                    // Merge with the free range directly after.
                    wa_next[0] = part_reg;
                    wd_next[0] = link_reg;
                    wa_next[1] = part_reg + SW'(1);
                    wd_next[1] = CW'(SW'(psize_reg) + space_s + HDR_S);
                    wa_next[3] = SW'(prev_reg);
                    wd_next[3] = CW'(part_reg);
                    we_next    = {has_prev_reg, 3'b011};
                    if (!has_prev_reg)
                    begin
                        head_valid_next = 1'b1;
                        head_next       = part_reg[AW-1:0];
                    end
                end
                else if (kind_reg == ffa_pkg::KIND_FREE &&
                         cur_reg + space_s + HDR_S == part_reg)
                begin
                    // Merge into the free range directly before.
                    wa_next[0] = cur_p1;
                    wd_next[0] = CW'(space_s + SW'(psize_reg) + HDR_S);
                    we_next    = 4'b0001;
                end
                else
                begin
                    prev_next     = cur_reg[AW-1:0];
                    has_prev_next = 1'b1;
                    cur_next      = link_s;
                    n_next        = n_reg + CNT_W'(1);
                end
            end
            ffa_pkg::S_WRITE:
            begin
                widx_next = widx_reg + 2'd1;
            end
            ffa_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
                widx_next = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ffa_pkg::S_CLEAR;
            clr_reg        <= '0;
            head_reg       <= '0;
            head_valid_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
            widx_reg       <= '0;
            we_reg         <= '0;
            rd_oob_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            head_reg       <= head_next;
            head_valid_reg <= head_valid_next;
            out_valid_reg  <= out_valid_next;
            widx_reg       <= widx_next;
            we_reg         <= we_next;
            rd_oob_reg     <= rd_oob_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        x_reg          <= x_next;
        prod_reg       <= prod_next;
        words_reg      <= words_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        has_prev_reg   <= has_prev_next;
        link_reg       <= link_next;
        psize_reg      <= psize_next;
        part_reg       <= part_next;
        adj_reg        <= adj_next;
        n_reg          <= n_next;
        wa_reg         <= wa_next;
        wd_reg         <= wd_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid       = out_valid_reg;
    assign granted_address = out_addr_reg;
    assign status          = out_status_reg;

    // An accepted request always leaves the idle state.
    `FFA_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != ffa_pkg::S_IDLE)
    // A failed result never carries an address.
    `FFA_ASSERT_NOW(a_fail_no_addr, out_valid && status != ffa_pkg::ST_OK, granted_address == '0)
    // A finished request with room in the output register is presented next cycle.
    `FFA_ASSERT_NEXT(a_done_presents, state_reg == ffa_pkg::S_DONE && out_free, out_valid)
    // No request is taken while the pool sweep runs.
    `FFA_ASSERT_NOW(a_clear_blocks, state_reg == ffa_pkg::S_CLEAR, !in_ready)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the first-fit free-list allocator.
// Depends on ffa_pkg and first_fit_free_list_allocator; predictor or table sets expectations.
`timescale 1ns / 1ps

module tb;
    import ffa_pkg::*;

    localparam int NPOOL      = POOL_WORDS_DEF;
    localparam int WBYTES     = WORD_BYTES_DEF;
    localparam int RAND_ITEMS = 730;

    typedef struct {
        logic                  kind;
        logic [BYTES_W-1:0]    nbytes;
        logic [FADDR_W-1:0]    faddr;
        bit                    typed;
        logic [FADDR_W-1:0]    want_addr;
        logic [STATUS_W-1:0]   want_status;
    } stim_row_t;

    typedef struct {
        logic [FADDR_W-1:0]    addr;
        logic [STATUS_W-1:0]   st;
    } alloc_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  kind = KIND_ALLOC;
    logic [BYTES_W-1:0]    request_bytes = '0;
    logic [FADDR_W-1:0]    free_address = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [FADDR_W-1:0]    granted_address;
    logic [STATUS_W-1:0]   status;

    // Predictor state: pool words, head of the free list and its valid flag.
    int unsigned   pool_mem [NPOOL];
    int unsigned   list_head;
    bit            list_live;
    alloc_result_t pending_results [$];
    int unsigned   held_addrs [$];
    int            mismatches = 0;
    int            checked = 0;
    int            n_alloc_ok = 0;
    int            n_no_fit = 0;
    int            n_frees = 0;
    bit            quiet_phase = 1'b0;

    first_fit_free_list_allocator u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .request_bytes   (request_bytes),
        .free_address    (free_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .granted_address (granted_address),
        .status          (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned pool_rd(int unsigned a);
        return (a < NPOOL) ? pool_mem[a] : 0;
    endfunction

    function automatic void pool_wr(int unsigned a, int unsigned v);
        if (a < NPOOL)
            pool_mem[a] = v & 32'h1FFFF;
    endfunction

    // Point the entry after prev, or the list head, at target.
    function automatic void splice(bit has_prev, int unsigned prev, int unsigned target);
        if (has_prev)
            pool_wr(prev, target);
        else if (target >= NPOOL)
        begin
            list_live = 1'b0;
            list_head = 0;
        end
        else
        begin
            list_head = target;
            list_live = 1'b1;
        end
    endfunction

    function automatic alloc_result_t carve_range(int unsigned nbytes);
        alloc_result_t r;
        int unsigned words, cur, prev, link, space, diff, repl, part;
        bit has_prev;
        words = (nbytes + WBYTES - 1) / WBYTES;
        cur = list_live ? list_head : NPOOL;
        prev = 0;
        has_prev = 1'b0;
        r.addr = '0;
        if (nbytes == 0)
        begin
            r.st = ST_ZERO;
            return r;
        end
        for (int n = 0; n < NPOOL && cur < NPOOL; n++)
        begin
            link = pool_rd(cur);
            space = pool_rd(cur + 1);
            if (space >= words)
            begin
                diff = space - words;
                repl = link;
                if (diff > 1)
                begin
                    part = cur + HDR_WORDS + words;
                    pool_wr(part, link);
                    pool_wr(part + 1, diff - HDR_WORDS);
                    pool_wr(cur + 1, words);
                    repl = part;
                end
                splice(has_prev, prev, repl);
                r.st = ST_OK;
                r.addr = FADDR_W'(cur + HDR_WORDS);
                return r;
            end
            prev = cur;
            has_prev = 1'b1;
            cur = link;
        end
        r.st = ST_NO_FIT;
        return r;
    endfunction

    function automatic logic [STATUS_W-1:0] return_range(int unsigned addr);
        int unsigned part, psize, adj, cur, prev, link, space;
        bit has_prev;
        if (addr == 0)
            return ST_OK;
        if (addr < HDR_WORDS)
            return ST_BAD_FREE;
        part = addr - HDR_WORDS;
        if (part + 1 >= NPOOL)
            return ST_BAD_FREE;
        psize = pool_rd(part + 1);
        adj = part + psize + HDR_WORDS;
        if (adj > NPOOL)
            return ST_BAD_FREE;
        cur = list_live ? list_head : NPOOL;
        prev = 0;
        has_prev = 1'b0;
        for (int n = 0; n < NPOOL && cur < NPOOL; n++)
        begin
            link = pool_rd(cur);
            space = pool_rd(cur + 1);
            // Free range directly after: absorb it and take its list slot.
            if (cur == adj)
            begin
                pool_wr(part, link);
                pool_wr(part + 1, psize + space + HDR_WORDS);
                splice(has_prev, prev, part);
                return ST_OK;
            end
            // Free range directly before: grow it over the freed one.
            if (cur + space + HDR_WORDS == part)
            begin
                pool_wr(cur + 1, space + psize + HDR_WORDS);
                return ST_OK;
            end
            prev = cur;
            has_prev = 1'b1;
            cur = link;
        end
        pool_wr(part, list_live ? list_head : NPOOL);
        list_head = part;
        list_live = 1'b1;
        return ST_OK;
    endfunction

    // Work out the result of an accepted transfer and track granted ranges.
    function automatic alloc_result_t predict_result(logic k, int unsigned nb, int unsigned fa);
        alloc_result_t r;
        if (k == KIND_ALLOC)
        begin
            r = carve_range(nb);
            if (r.st == ST_OK)
            begin
                held_addrs.push_back(r.addr);
                n_alloc_ok++;
            end
            else if (r.st == ST_NO_FIT)
                n_no_fit++;
        end
        else
        begin
            r.addr = '0;
            r.st = return_range(fa);
            n_frees++;
        end
        return r;
    endfunction

    // Offer one request and record its expected result on acceptance.
    task automatic send_request(stim_row_t row);
        alloc_result_t r;
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= row.kind;
        request_bytes <= row.nbytes;
        free_address <= row.faddr;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        r = predict_result(row.kind, row.nbytes, row.faddr);
        if (row.typed && (r.addr !== row.want_addr || r.st !== row.want_status))
            $display("tb: note, table row disagrees with predictor (addr %0d st %0d)",
                     r.addr, r.st);
        if (row.typed)
        begin
            r.addr = row.want_addr;
            r.st = row.want_status;
        end
        pending_results.push_back(r);
        @(negedge clk);
    endtask

    function automatic stim_row_t mk(logic k, int unsigned nb, int unsigned fa, bit typed,
                                     int unsigned wa, logic [STATUS_W-1:0] ws);
        stim_row_t row;
        row.kind = k;
        row.nbytes = BYTES_W'(nb);
        row.faddr = FADDR_W'(fa);
        row.typed = typed;
        row.want_addr = FADDR_W'(wa);
        row.want_status = ws;
        return row;
    endfunction

    // Stimulus: directed table, then mostly well-formed alloc/free traffic.
    initial
    begin
        stim_row_t table_rows [$];
        stim_row_t row;
        int idx;
        for (int i = 0; i < NPOOL; i++)
            pool_mem[i] = 0;
        pool_mem[0] = NPOOL;
        pool_mem[1] = NPOOL - HDR_WORDS;
        list_head = 0;
        list_live = 1'b1;

        table_rows.push_back(mk(KIND_ALLOC, 0, 0, 1, 0, ST_ZERO));
        table_rows.push_back(mk(KIND_FREE, 0, 0, 1, 0, ST_OK));
        table_rows.push_back(mk(KIND_FREE, 0, 1, 1, 0, ST_BAD_FREE));
        table_rows.push_back(mk(KIND_ALLOC, 32768, 0, 1, 0, ST_NO_FIT));
        table_rows.push_back(mk(KIND_ALLOC, 32752, 0, 1, 2, ST_OK));
        table_rows.push_back(mk(KIND_ALLOC, 1, 0, 1, 0, ST_NO_FIT));
        table_rows.push_back(mk(KIND_FREE, 0, 2, 1, 0, ST_OK));
        table_rows.push_back(mk(KIND_ALLOC, 8, 4095, 1, 2, ST_OK));
        table_rows.push_back(mk(KIND_ALLOC, 9, 0, 0, 0, ST_OK));
        table_rows.push_back(mk(KIND_ALLOC, 64, 0, 0, 0, ST_OK));
        table_rows.push_back(mk(KIND_ALLOC, 24, 0, 0, 0, ST_OK));
        table_rows.push_back(mk(KIND_ALLOC, 1000, 0, 0, 0, ST_OK));
        table_rows.push_back(mk(KIND_FREE, 0, 6, 0, 0, ST_OK));
        table_rows.push_back(mk(KIND_FREE, 0, 2, 0, 0, ST_OK));
        table_rows.push_back(mk(KIND_ALLOC, 16, 0, 0, 0, ST_OK));
        table_rows.push_back(mk(KIND_FREE, 16'hFFFF, 4095, 0, 0, ST_OK));
        table_rows.push_back(mk(KIND_FREE, 0, 4094, 0, 0, ST_OK));
        table_rows.push_back(mk(KIND_ALLOC, 20000, 0, 0, 0, ST_OK));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (table_rows[i])
            send_request(table_rows[i]);
        held_addrs.delete();

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 100 == 50)
                quiet_phase = 1'b1;
            else if (i % 100 == 80)
                quiet_phase = 1'b0;
            row = mk(KIND_ALLOC, 0, 0, 0, 0, ST_OK);
            if (held_addrs.size() > 0 && $urandom_range(0, 99) < (held_addrs.size() > 30 ? 70 : 40))
            begin
                row.kind = KIND_FREE;
                row.nbytes = BYTES_W'($urandom());
                idx = $urandom_range(0, held_addrs.size() - 1);
                row.faddr = FADDR_W'(held_addrs[idx]);
                held_addrs.delete(idx);
            end
            else if ($urandom_range(0, 99) < 6)
            begin
                // Noise: null, malformed or arbitrary frees.
                row.kind = KIND_FREE;
                case ($urandom_range(0, 3))
                    0: row.faddr = '0;
                    1: row.faddr = FADDR_W'(1);
                    2: row.faddr = FADDR_W'(4095);
                    default: row.faddr = FADDR_W'($urandom());
                endcase
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0: row.nbytes = '0;
                    1: row.nbytes = BYTES_W'($urandom_range(0, 32768));
                    2: row.nbytes = BYTES_W'($urandom_range(2048, 8192));
                    default: row.nbytes = BYTES_W'($urandom_range(1, 320));
                endcase
                row.faddr = FADDR_W'($urandom());
            end
            send_request(row);
        end
        in_valid <= 1'b0;

        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("tb: %0d results checked: %0d grants, %0d no-fit, %0d frees",
                 checked, n_alloc_ok, n_no_fit, n_frees);
        $display("tb: %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Receiver: random stall before each transfer, with stall-free stretches.
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = quiet_phase ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        alloc_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected result addr %0d status %0d",
                             granted_address, status);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (granted_address !== exp_r.addr || status !== exp_r.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                                 exp_r.addr, exp_r.st, granted_address, status);
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        #300ms;
        $display("tb: timeout with %0d results outstanding", pending_results.size());
        $display("tb: FAIL");
        $finish;
    end

endmodule
